FILE: design/numfmt_pkg.sv
// ----------------------------------------------------------------------------
// numfmt_pkg: shared types and microcode for the number formatter
// Format codes, control word layout, the control program and the digit map.
// ----------------------------------------------------------------------------
package numfmt_pkg;

    // Format selector codes
    typedef logic [2:0] t_fmt;
    localparam t_fmt FMT_UDEC = 3'd0;
    localparam t_fmt FMT_SDEC = 3'd1;
    localparam t_fmt FMT_HEX  = 3'd2;
    localparam t_fmt FMT_OCT  = 3'd3;
    localparam t_fmt FMT_BIN  = 3'd4;

    localparam int VALUE_W    = 32;
    localparam int TOP_W      = 5;
    localparam int CHAR_W     = 8;
    localparam int DIG_W      = 4;
    // Octal needs the most stacked digits for a 32-bit number; binary is not stacked
    localparam int MAX_DIGITS = 11;
    localparam int STACK_W    = MAX_DIGITS * DIG_W;
    localparam int CNT_W      = $clog2(MAX_DIGITS + 1);

    // Divide by ten: floor(x * 0xCCCCCCCD / 2^35) is exact for all 32-bit x
    localparam logic [VALUE_W-1:0] DEC_RECIP = 32'hCCCC_CCCD;
    localparam int                 DEC_SHIFT = 35;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] CHAR_ALPHA = 8'd65;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

    // Micro-operations driving the datapath
    typedef enum logic [2:0] {
        OP_WAIT,   // accept a transaction, load operands
        OP_NOP,    // decision only
        OP_SIGN,   // emit '-' and negate when signed and negative
        OP_QUOT,   // form quotient of the working value
        OP_DIGIT,  // form remainder, push digit, advance value
        OP_POP,    // emit the top digit of the stack
        OP_BIT     // emit one binary digit
    } t_op;

    // Jump conditions
    typedef enum logic [2:0] {
        C_ALWAYS,
        C_IN_ACC,
        C_FMT_BIN,
        C_FMT_BAD,
        C_Q_NZ,
        C_DIG_MORE,
        C_BIT_MORE
    } t_cond;

    typedef logic [2:0] t_upc;

    // Step labels
    localparam t_upc ST_WAIT  = 3'd0;
    localparam t_upc ST_DISP  = 3'd1;
    localparam t_upc ST_SIGN  = 3'd2;
    localparam t_upc ST_QUOT  = 3'd3;
    localparam t_upc ST_DIGIT = 3'd4;
    localparam t_upc ST_POP   = 3'd5;
    localparam t_upc ST_BIT   = 3'd6;
    localparam t_upc ST_SPARE = 3'd7;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_upc  jt;   // next step when the condition holds
        t_upc  jf;   // next step otherwise
    } t_ctrl;

    // Control program
    function automatic t_ctrl ucode(input t_upc pc);
        t_ctrl w;
        unique case (pc)
            ST_WAIT:  w = '{OP_WAIT,  C_IN_ACC,   ST_DISP,  ST_WAIT};
            ST_DISP:  w = '{OP_NOP,   C_FMT_BIN,  ST_BIT,   ST_SIGN};
            ST_SIGN:  w = '{OP_SIGN,  C_FMT_BAD,  ST_WAIT,  ST_QUOT};
            ST_QUOT:  w = '{OP_QUOT,  C_ALWAYS,   ST_DIGIT, ST_DIGIT};
            ST_DIGIT: w = '{OP_DIGIT, C_Q_NZ,     ST_QUOT,  ST_POP};
            ST_POP:   w = '{OP_POP,   C_DIG_MORE, ST_POP,   ST_WAIT};
            ST_BIT:   w = '{OP_BIT,   C_BIT_MORE, ST_BIT,   ST_WAIT};
            default:  w = '{OP_NOP,   C_ALWAYS,   ST_WAIT,  ST_WAIT};
        endcase
        return w;
    endfunction

    // Digit value to ASCII: 0-9 then uppercase letters
    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIG_W-1:0] d);
        logic [CHAR_W-1:0] r;
        if (d > 4'd9) begin
            r = CHAR_ALPHA + CHAR_W'(d) - 8'd10;
        end else begin
            r = CHAR_ZERO + CHAR_W'(d);
        end
        return r;
    endfunction

endpackage

FILE: design/number_to_ascii_formatter.sv
// ----------------------------------------------------------------------------
// number_to_ascii_formatter: integer to ASCII character stream
// Microcoded sequencer converting one 32-bit number per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_ready) carries one number with its format code
//   (0 unsigned decimal, 1 signed decimal, 2 hex, 3 octal, 4 binary) and, for
//   binary, the index of the top bit to print. Output channel
//   (o_valid / i_ready) carries one ASCII character per transaction, most
//   significant digit first, with o_last set on the final character.
//   Unused format codes 5..7 are accepted and produce no characters.
//   Timing: a transaction is taken only in the wait step. Radix formats go
//   through the wait, dispatch and sign steps, then form the quotient, then
//   the remainder and push, for each digit, then pop one character per digit
//   from the digit stack. Binary goes through the wait and dispatch steps,
//   then emits one digit per cycle while the receiver keeps up. The per-digit
//   quotient/remainder loop dominates the time for radix formats.
//   The last character sits in the output register while the next number is
//   accepted. If the receiver stalls, the emitting step holds until the
//   output register frees up; nothing is dropped.
//   Reset (synchronous, active low) returns the sequencer to the wait step
//   and empties the output register.
// ----------------------------------------------------------------------------
module number_to_ascii_formatter (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [2:0]                      i_func,
    input  logic [numfmt_pkg::VALUE_W-1:0]  i_value,
    input  logic [numfmt_pkg::TOP_W-1:0]    i_top_bit,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [numfmt_pkg::CHAR_W-1:0]   o_character,
    output logic                            o_last
);
    import numfmt_pkg::*;

    // Sequencer and datapath registers
    t_upc                r_upc,   n_upc;
    t_fmt                r_func,  n_func;
    logic [VALUE_W-1:0]  r_num,   n_num;
    logic [VALUE_W-1:0]  r_q,     n_q;
    logic [TOP_W-1:0]    r_top,   n_top;
    logic [STACK_W-1:0]  r_dig,   n_dig;
    logic [CNT_W-1:0]    r_cnt,   n_cnt;
    logic                r_ovld,  n_ovld;
    logic [CHAR_W-1:0]   r_char,  n_char;
    logic                r_last,  n_last;

    t_ctrl               w_ctrl;
    logic                w_emit_ok;
    logic                w_hold;
    logic                w_cond;
    logic [2*VALUE_W-1:0] w_prod;
    logic [VALUE_W-1:0]  w_qr;
    logic [VALUE_W-1:0]  w_rem;
    logic [DIG_W-1:0]    w_digit;

    assign w_ctrl    = ucode(r_upc);
    // Output register can take a character this cycle
    assign w_emit_ok = !r_ovld || i_ready;
    // Emitting steps hold while the receiver stalls
    assign w_hold    = (w_ctrl.op == OP_SIGN || w_ctrl.op == OP_POP ||
                        w_ctrl.op == OP_BIT) && !w_emit_ok;

    // Reciprocal multiply for divide by ten
    assign w_prod = (2*VALUE_W)'(r_num) * (2*VALUE_W)'(DEC_RECIP);

    // Quotient times radix, then remainder
    always_comb begin
        case (r_func)
            FMT_HEX: w_qr = r_q << 4;
            FMT_OCT: w_qr = r_q << 3;
            default: w_qr = (r_q << 3) + (r_q << 1);
        endcase
    end
    assign w_rem   = r_num - w_qr;
    assign w_digit = w_rem[DIG_W-1:0];

    // Jump condition select
    always_comb begin
        unique case (w_ctrl.cond)
            C_ALWAYS:   w_cond = 1'b1;
            C_IN_ACC:   w_cond = i_valid;
            C_FMT_BIN:  w_cond = (r_func == FMT_BIN);
            C_FMT_BAD:  w_cond = (r_func > FMT_BIN);
            C_Q_NZ:     w_cond = (r_q != '0);
            C_DIG_MORE: w_cond = (r_cnt > CNT_W'(1));
            C_BIT_MORE: w_cond = (r_top != '0);
            default:    w_cond = 1'b0;
        endcase
    end

    // Datapath actions per micro-operation
    always_comb begin
        n_func = r_func;
        n_num  = r_num;
        n_q    = r_q;
        n_top  = r_top;
        n_dig  = r_dig;
        n_cnt  = r_cnt;
        n_char = r_char;
        n_last = r_last;
        // Drop the held character once it is taken
        n_ovld = r_ovld && !i_ready;
        n_upc  = w_cond ? w_ctrl.jt : w_ctrl.jf;

        if (w_hold) begin
            n_upc = r_upc;
        end else begin
            unique case (w_ctrl.op)
                OP_WAIT: begin
                    if (i_valid) begin
                        n_func = i_func;
                        n_num  = i_value;
                        n_top  = i_top_bit;
                        n_cnt  = '0;
                    end
                end
                OP_NOP: begin
                end
                OP_SIGN: begin
                    if (r_func == FMT_SDEC && r_num[VALUE_W-1]) begin
                        n_num  = '0 - r_num;
                        n_ovld = 1'b1;
                        n_char = CHAR_MINUS;
                        n_last = 1'b0;
                    end
                end
                OP_QUOT: begin
                    case (r_func)
                        FMT_HEX: n_q = r_num >> 4;
                        FMT_OCT: n_q = r_num >> 3;
                        default: n_q = VALUE_W'(w_prod >> DEC_SHIFT);
                    endcase
                end
                OP_DIGIT: begin
                    // Push onto the low end; the last pushed digit pops first
                    n_dig = {r_dig[STACK_W-DIG_W-1:0], w_digit};
                    n_cnt = r_cnt + CNT_W'(1);
                    n_num = r_q;
                end
                OP_POP: begin
                    n_ovld = 1'b1;
                    n_char = digit_char(r_dig[DIG_W-1:0]);
                    n_last = (r_cnt == CNT_W'(1));
                    n_dig  = r_dig >> DIG_W;
                    n_cnt  = r_cnt - CNT_W'(1);
                end
                OP_BIT: begin
                    n_ovld = 1'b1;
                    n_char = r_num[r_top] ? (CHAR_ZERO + 8'd1) : CHAR_ZERO;
                    n_last = (r_top == '0);
                    n_top  = r_top - TOP_W'(1);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc  <= ST_WAIT;
            r_ovld <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_upc  <= n_upc;
            r_ovld <= n_ovld;
            r_cnt  <= n_cnt;
        end
        r_func <= n_func;
        r_num  <= n_num;
        r_q    <= n_q;
        r_top  <= n_top;
        r_dig  <= n_dig;
        r_char <= n_char;
        r_last <= n_last;
    end

    assign o_ready     = (r_upc == ST_WAIT);
    assign o_valid     = r_ovld;
    assign o_character = r_char;
    assign o_last      = r_last;

    // Digit stack never overflows
    a_stack_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_DIGITS))
        else $error("digit stack overflow");

    // Popping only happens with digits on the stack
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_upc == ST_POP) |-> (r_cnt != '0))
        else $error("pop from empty digit stack");

    // Binary step only runs for the binary format
    a_bin_fmt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_upc == ST_BIT) |-> (r_func == FMT_BIN))
        else $error("binary step with wrong format");

    // A number is taken only in the wait step and always moves the sequencer to dispatch
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_upc == ST_DISP))
        else $error("accepted transaction did not start dispatch");

endmodule
